### rtl/tkbd_pkg.sv
// Package for the terminal key byte decoder: key codes, byte constants,
// event and controller/datapath interface types. No dependencies.
`timescale 1ns / 1ps

package tkbd_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned SEQ_LEN_W = 7;
    localparam int unsigned NUM_W     = 16;
    localparam int unsigned MAX_EV    = 4;
    localparam int unsigned EV_CNT_W  = 3;
    localparam int unsigned EV_IDX_W  = 2;

    typedef enum logic [3:0] {
        K_CP    = 4'd0,
        K_QUIT  = 4'd1,
        K_ESC   = 4'd2,
        K_UP    = 4'd3,
        K_DOWN  = 4'd4,
        K_RIGHT = 4'd5,
        K_LEFT  = 4'd6,
        K_HOME  = 4'd7,
        K_END   = 4'd8,
        K_DEL   = 4'd9,
        K_PGUP  = 4'd10,
        K_PGDN  = 4'd11,
        K_BS    = 4'd12,
        K_TAB   = 4'd13,
        K_CR    = 4'd14,
        K_NL    = 4'd15
    } t_kind;

    // Byte values
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_CTRL_C   = 8'h03;
    localparam logic [7:0] CH_CTRL_Q   = 8'h11;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_DEL      = 8'h7f;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_O        = 8'h4f;
    localparam logic [7:0] CH_TILDE    = 8'h7e;
    localparam logic [7:0] CH_FIN_LO   = 8'h40;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_F        = 8'h46;
    localparam logic [7:0] CH_H        = 8'h48;

    // UTF-8 lead/trail classification
    localparam logic [7:0] UTF_TRAIL_MASK = 8'hC0;
    localparam logic [7:0] UTF_TRAIL_VAL  = 8'h80;
    localparam logic [7:0] UTF_LEAD2_MASK = 8'hE0;
    localparam logic [7:0] UTF_LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] UTF_LEAD3_MASK = 8'hF0;
    localparam logic [7:0] UTF_LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] UTF_LEAD4_MASK = 8'hF8;
    localparam logic [7:0] UTF_LEAD4_VAL  = 8'hF0;
    localparam logic [7:0] UTF_PAYLOAD    = 8'h3F;

    // Tilde key numbers
    localparam logic [NUM_W-1:0] NUM_HOME = 16'd1;
    localparam logic [NUM_W-1:0] NUM_DEL  = 16'd3;
    localparam logic [NUM_W-1:0] NUM_END  = 16'd4;
    localparam logic [NUM_W-1:0] NUM_PGUP = 16'd5;
    localparam logic [NUM_W-1:0] NUM_PGDN = 16'd6;
    localparam logic [NUM_W-1:0] NUM_SAT  = 16'hFFFF;

    typedef struct packed {
        t_kind           kind;
        logic [CP_W-1:0] cp;
    } t_event;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;   // input item taken, latch events and update state
        logic step;   // current event taken downstream
    } t_dp_cmd;

    typedef struct packed {
        logic has_events;  // byte on the input would give at least one event
        logic last;        // event being shown is the final one
    } t_dp_status;

endpackage

### rtl/tkbd_datapath.sv
// Datapath of the terminal key byte decoder: escape/CSI and UTF-8 state,
// per-byte event computation and the event buffer. Uses tkbd_pkg.
`timescale 1ns / 1ps

module tkbd_datapath
    import tkbd_pkg::*;
#(
    parameter int unsigned SEQ_LIMIT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [7:0]          i_byte,
    output t_dp_status          o_status,
    output t_kind               o_kind,
    output logic [CP_W-1:0]     o_cp,
    output logic                o_last
);

    localparam logic [SEQ_LEN_W-1:0] LIMIT = SEQ_LEN_W'(SEQ_LIMIT);

    // decoder state
    logic [SEQ_LEN_W-1:0] r_seq_len,    n_seq_len;
    logic [7:0]           r_seq_second, n_seq_second;
    logic [NUM_W-1:0]     r_seq_num,    n_seq_num;
    logic                 r_seq_ok,     n_seq_ok;
    logic [CP_W-1:0]      r_utf_part,   n_utf_part;
    logic [1:0]           r_utf_needed, n_utf_needed;
    logic [7:0]           r_utf_lead,   n_utf_lead;
    logic [1:0]           r_held_cnt,   n_held_cnt;
    logic [7:0]           r_held [2];
    logic [7:0]           n_held [2];

    // event buffer
    t_event               r_ev [MAX_EV];
    t_event               n_ev [MAX_EV];
    logic [EV_CNT_W-1:0]  r_ev_cnt, n_ev_cnt;
    logic [EV_IDX_W-1:0]  r_idx;

    logic [SEQ_LEN_W-1:0] len;
    logic [19:0]          num_ext;
    logic                 done;
    logic                 use_plain;
    logic [CP_W-1:0]      shifted;

    always_comb begin
        n_seq_len    = r_seq_len;
        n_seq_second = r_seq_second;
        n_seq_num    = r_seq_num;
        n_seq_ok     = r_seq_ok;
        n_utf_part   = r_utf_part;
        n_utf_needed = r_utf_needed;
        n_utf_lead   = r_utf_lead;
        n_held_cnt   = r_held_cnt;
        n_held       = r_held;
        for (int i = 0; i < MAX_EV; i++) begin
            n_ev[i] = '{kind: K_CP, cp: '0};
        end
        n_ev_cnt  = '0;
        len       = r_seq_len + SEQ_LEN_W'(1);
        num_ext   = ({4'd0, r_seq_num} << 3) + ({4'd0, r_seq_num} << 1)
                  + {16'd0, i_byte[3:0] - CH_ZERO[3:0]};
        done      = 1'b0;
        use_plain = 1'b0;
        shifted   = {r_utf_part[CP_W-7:0], i_byte[5:0] & UTF_PAYLOAD[5:0]};

        if (r_seq_len != '0) begin
            n_seq_len = len;
            if (len == SEQ_LEN_W'(2)) begin
                n_seq_second = i_byte;
                if (i_byte != CH_LBRACKET && i_byte != CH_O) begin
                    n_ev[0]  = '{kind: K_ESC, cp: '0};
                    n_ev_cnt = EV_CNT_W'(1);
                    if (i_byte == CH_ESC) begin
                        n_seq_len    = SEQ_LEN_W'(1);
                        n_seq_second = '0;
                        n_seq_num    = '0;
                        n_seq_ok     = 1'b1;
                    end else begin
                        // escape then the byte itself, raw
                        n_seq_len = '0;
                        n_ev[1]   = '{kind: K_CP, cp: {13'd0, i_byte}};
                        n_ev_cnt  = EV_CNT_W'(2);
                    end
                    done = 1'b1;
                end
            end else if (r_seq_second == CH_LBRACKET && len >= SEQ_LEN_W'(3)) begin
                if (i_byte inside {[CH_FIN_LO:CH_TILDE]}) begin
                    n_seq_len = '0;
                    done      = 1'b1;
                    if (len == SEQ_LEN_W'(3)) begin
                        n_ev_cnt = EV_CNT_W'(1);
                        case (i_byte)
                            CH_A:    n_ev[0].kind = K_UP;
                            CH_B:    n_ev[0].kind = K_DOWN;
                            CH_C:    n_ev[0].kind = K_RIGHT;
                            CH_D:    n_ev[0].kind = K_LEFT;
                            CH_H:    n_ev[0].kind = K_HOME;
                            CH_F:    n_ev[0].kind = K_END;
                            default: n_ev_cnt     = '0;
                        endcase
                    end else if (i_byte == CH_TILDE && r_seq_ok) begin
                        n_ev_cnt = EV_CNT_W'(1);
                        case (r_seq_num)
                            NUM_HOME: n_ev[0].kind = K_HOME;
                            NUM_DEL:  n_ev[0].kind = K_DEL;
                            NUM_END:  n_ev[0].kind = K_END;
                            NUM_PGUP: n_ev[0].kind = K_PGUP;
                            NUM_PGDN: n_ev[0].kind = K_PGDN;
                            default:  n_ev_cnt     = '0;
                        endcase
                    end
                end else if (i_byte inside {[CH_ZERO:CH_NINE]}) begin
                    n_seq_num = (num_ext > {4'd0, NUM_SAT}) ? NUM_SAT : num_ext[NUM_W-1:0];
                end else begin
                    n_seq_ok = 1'b0;
                end
            end
            if (!done && len >= LIMIT) begin
                n_seq_len = '0;
            end
        end else if (r_utf_needed != '0) begin
            if ((i_byte & UTF_TRAIL_MASK) == UTF_TRAIL_VAL) begin
                n_utf_part   = shifted;
                n_utf_needed = r_utf_needed - 2'd1;
                if (r_utf_needed == 2'd1) begin
                    n_held_cnt = '0;
                    if (shifted != '0) begin
                        n_ev[0]  = '{kind: K_CP, cp: shifted};
                        n_ev_cnt = EV_CNT_W'(1);
                    end
                end else begin
                    n_held[r_held_cnt[0]] = i_byte;
                    n_held_cnt            = r_held_cnt + 2'd1;
                end
            end else begin
                // broken sequence: lead and held trails go out raw
                n_ev[0]  = '{kind: K_CP, cp: {13'd0, r_utf_lead}};
                n_ev_cnt = EV_CNT_W'(1);
                if (r_held_cnt != '0) begin
                    n_ev[1]  = '{kind: K_CP, cp: {13'd0, r_held[0]}};
                    n_ev_cnt = EV_CNT_W'(2);
                end
                if (r_held_cnt > 2'd1) begin
                    n_ev[2]  = '{kind: K_CP, cp: {13'd0, r_held[1]}};
                    n_ev_cnt = EV_CNT_W'(3);
                end
                n_utf_needed = '0;
                n_held_cnt   = '0;
                n_utf_part   = '0;
                use_plain    = 1'b1;
            end
        end else begin
            use_plain = 1'b1;
        end

        if (use_plain) begin
            if (i_byte == CH_CTRL_C || i_byte == CH_CTRL_Q) begin
                n_ev[n_ev_cnt[EV_IDX_W-1:0]] = '{kind: K_QUIT, cp: '0};
                n_ev_cnt = n_ev_cnt + EV_CNT_W'(1);
            end else if (i_byte == CH_ESC) begin
                n_seq_len    = SEQ_LEN_W'(1);
                n_seq_second = '0;
                n_seq_num    = '0;
                n_seq_ok     = 1'b1;
            end else if (i_byte == CH_BS || i_byte == CH_DEL) begin
                n_ev[n_ev_cnt[EV_IDX_W-1:0]] = '{kind: K_BS, cp: '0};
                n_ev_cnt = n_ev_cnt + EV_CNT_W'(1);
            end else if (i_byte == CH_TAB) begin
                n_ev[n_ev_cnt[EV_IDX_W-1:0]] = '{kind: K_TAB, cp: '0};
                n_ev_cnt = n_ev_cnt + EV_CNT_W'(1);
            end else if (i_byte == CH_CR) begin
                n_ev[n_ev_cnt[EV_IDX_W-1:0]] = '{kind: K_CR, cp: '0};
                n_ev_cnt = n_ev_cnt + EV_CNT_W'(1);
            end else if (i_byte == CH_LF) begin
                n_ev[n_ev_cnt[EV_IDX_W-1:0]] = '{kind: K_NL, cp: '0};
                n_ev_cnt = n_ev_cnt + EV_CNT_W'(1);
            end else if (!i_byte[7]) begin
                if (i_byte != CH_NUL) begin
                    n_ev[n_ev_cnt[EV_IDX_W-1:0]] = '{kind: K_CP, cp: {13'd0, i_byte}};
                    n_ev_cnt = n_ev_cnt + EV_CNT_W'(1);
                end
            end else if ((i_byte & UTF_LEAD2_MASK) == UTF_LEAD2_VAL) begin
                n_utf_part   = {16'd0, i_byte[4:0]};
                n_utf_needed = 2'd1;
                n_utf_lead   = i_byte;
                n_held_cnt   = '0;
            end else if ((i_byte & UTF_LEAD3_MASK) == UTF_LEAD3_VAL) begin
                n_utf_part   = {17'd0, i_byte[3:0]};
                n_utf_needed = 2'd2;
                n_utf_lead   = i_byte;
                n_held_cnt   = '0;
            end else if ((i_byte & UTF_LEAD4_MASK) == UTF_LEAD4_VAL) begin
                n_utf_part   = {18'd0, i_byte[2:0]};
                n_utf_needed = 2'd3;
                n_utf_lead   = i_byte;
                n_held_cnt   = '0;
            end else begin
                // stray trail byte or unused lead
                n_ev[n_ev_cnt[EV_IDX_W-1:0]] = '{kind: K_CP, cp: {13'd0, i_byte}};
                n_ev_cnt = n_ev_cnt + EV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len    <= '0;
            r_seq_second <= '0;
            r_seq_num    <= '0;
            r_seq_ok     <= 1'b1;
            r_utf_part   <= '0;
            r_utf_needed <= '0;
            r_utf_lead   <= '0;
            r_held_cnt   <= '0;
            r_ev_cnt     <= '0;
            r_idx        <= '0;
        end else if (i_cmd.load) begin
            r_seq_len    <= n_seq_len;
            r_seq_second <= n_seq_second;
            r_seq_num    <= n_seq_num;
            r_seq_ok     <= n_seq_ok;
            r_utf_part   <= n_utf_part;
            r_utf_needed <= n_utf_needed;
            r_utf_lead   <= n_utf_lead;
            r_held_cnt   <= n_held_cnt;
            r_ev_cnt     <= n_ev_cnt;
            r_idx        <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + EV_IDX_W'(1);
        end
    end

    // held trail bytes and event payloads carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_held <= n_held;
            r_ev   <= n_ev;
        end
    end

    assign o_status.has_events = (n_ev_cnt != '0);
    assign o_status.last       = ({1'b0, r_idx} + EV_CNT_W'(1)) == r_ev_cnt;
    assign o_kind              = r_ev[r_idx].kind;
    assign o_cp                = r_ev[r_idx].cp;
    assign o_last              = o_status.last;

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> ({1'b0, r_idx} < r_ev_cnt))
        else $error("event step beyond buffered count");

    a_held_only_mid_utf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_utf_needed == '0) |-> (r_held_cnt == '0))
        else $error("held trail bytes without open UTF-8 sequence");

    a_seq_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_len < LIMIT)
        else $error("escape sequence length reached limit without closing");

endmodule

### rtl/tkbd_ctrl.sv
// Controller of the terminal key byte decoder: takes a byte, then hands
// out its buffered events one per output handshake. Uses tkbd_pkg.
`timescale 1ns / 1ps

module tkbd_ctrl
    import tkbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && i_status.has_events) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_m_tready && i_status.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_EMIT: begin
                o_m_tvalid = 1'b1;
                o_cmd.step = i_m_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_no_load_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.step))
        else $error("byte taken while events still pending");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && i_status.last) |=> o_s_tready)
        else $error("controller did not return to idle after last event");

    a_ready_excludes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid)
        else $error("input ready while an event is on offer");

endmodule

### rtl/terminal_key_byte_decoder.sv
// Terminal key byte decoder, top level: controller and datapath.
// Depends on tkbd_pkg, tkbd_ctrl and tkbd_datapath.
//
// Takes raw terminal input bytes on the slave stream and gives key events on
// the master stream: quit, escape, arrow/Home/End/tilde keys from ESC [
// sequences, named control keys and UTF-8 codepoints. The key kind travels on
// tuser and the codepoint on tdata. A byte gives zero to four events; tlast
// marks the final event of a byte. A byte is taken while the controller is idle,
// after which the controller reads its events out of the event buffer one per
// cycle while the output is ready; output stalls hold the readout. No new byte
// is taken until the last event of the previous one has been taken.
// SEQ_LIMIT (4..127) bounds the length of an escape sequence.
`timescale 1ns / 1ps

module terminal_key_byte_decoder
    import tkbd_pkg::*;
#(
    parameter int unsigned SEQ_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] byte_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [3:0]  o_m_tuser,   // [3:0] key_kind
    output logic        o_m_tlast    // last_of_run
);

    t_dp_cmd         cmd;
    t_dp_status      status;
    t_kind           kind;
    logic [CP_W-1:0] cp;

    tkbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    tkbd_datapath #(
        .SEQ_LIMIT (SEQ_LIMIT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (i_s_tdata),
        .o_status (status),
        .o_kind   (kind),
        .o_cp     (cp),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {3'd0, cp};
    assign o_m_tuser = kind;

endmodule

### verif/terminal_key_byte_decoder_checker.sv
// Checker for the terminal key byte decoder: watches both streams, predicts
// the key events of every byte taken and compares them with what comes out.
// Depends on tkbd_pkg.
`timescale 1ns / 1ps

module terminal_key_byte_decoder_checker
    import tkbd_pkg::*;
#(
    parameter int unsigned SEQ_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] byte_in
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,      // [20:0] code_point, [23:21] zero
    input  logic [3:0]  i_m_tuser,      // [3:0] key_kind
    input  logic        i_m_tlast,      // last_of_run
    output int unsigned o_mismatches,
    output int unsigned o_awaited,
    output int unsigned o_events_seen
);

    typedef struct packed {
        t_kind           kind;
        logic [CP_W-1:0] cp;
        logic            last;
    } t_key_event;

    t_key_event awaited_events[$];
    t_key_event byte_events[$];

    // escape sequence tracking
    logic [SEQ_LEN_W-1:0] esc_len;
    logic [7:0]           esc_intro;
    logic [NUM_W-1:0]     esc_num;
    logic                 esc_digits_ok;
    // UTF-8 tracking
    logic [CP_W-1:0]      utf_acc;
    logic [1:0]           utf_left;
    logic [7:0]           utf_first;
    logic [1:0]           utf_nheld;
    logic [7:0]           utf_held [2];

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        o_mismatches++;
        if (o_mismatches <= 30)
            $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic void add_event(t_kind kind, logic [CP_W-1:0] cp);
        t_key_event ev;
        if (byte_events.size() >= MAX_EV)
            return;
        ev.kind = kind;
        ev.cp   = (kind == K_CP) ? cp : '0;
        ev.last = 1'b0;
        byte_events.push_back(ev);
    endfunction

    function automatic void open_escape();
        esc_len       = SEQ_LEN_W'(1);
        esc_intro     = '0;
        esc_num       = '0;
        esc_digits_ok = 1'b1;
    endfunction

    function automatic void plain_key(logic [7:0] c);
        if (c == CH_CTRL_C || c == CH_CTRL_Q) begin
            add_event(K_QUIT, '0);
        end else if (c == CH_ESC) begin
            open_escape();
        end else if (c == CH_BS || c == CH_DEL) begin
            add_event(K_BS, '0);
        end else if (c == CH_TAB) begin
            add_event(K_TAB, '0);
        end else if (c == CH_CR) begin
            add_event(K_CR, '0);
        end else if (c == CH_LF) begin
            add_event(K_NL, '0);
        end else if (!c[7]) begin
            if (c != CH_NUL)
                add_event(K_CP, CP_W'(c));
        end else if ((c & UTF_LEAD2_MASK) == UTF_LEAD2_VAL) begin
            utf_acc = CP_W'(c[4:0]); utf_left = 2'd1; utf_first = c; utf_nheld = '0;
        end else if ((c & UTF_LEAD3_MASK) == UTF_LEAD3_VAL) begin
            utf_acc = CP_W'(c[3:0]); utf_left = 2'd2; utf_first = c; utf_nheld = '0;
        end else if ((c & UTF_LEAD4_MASK) == UTF_LEAD4_VAL) begin
            utf_acc = CP_W'(c[2:0]); utf_left = 2'd3; utf_first = c; utf_nheld = '0;
        end else begin
            // stray trail byte or an invalid lead goes out raw
            add_event(K_CP, CP_W'(c));
        end
    endfunction

    function automatic void finish_csi(logic [SEQ_LEN_W-1:0] len, logic [7:0] fin);
        if (len == 3) begin
            case (fin)
                CH_A:    add_event(K_UP, '0);
                CH_B:    add_event(K_DOWN, '0);
                CH_C:    add_event(K_RIGHT, '0);
                CH_D:    add_event(K_LEFT, '0);
                CH_H:    add_event(K_HOME, '0);
                CH_F:    add_event(K_END, '0);
                default: ;
            endcase
        end else if (fin == CH_TILDE && esc_digits_ok) begin
            case (esc_num)
                NUM_HOME: add_event(K_HOME, '0);
                NUM_DEL:  add_event(K_DEL, '0);
                NUM_END:  add_event(K_END, '0);
                NUM_PGUP: add_event(K_PGUP, '0);
                NUM_PGDN: add_event(K_PGDN, '0);
                default:  ;
            endcase
        end
    endfunction

    function automatic void escape_byte(logic [7:0] c);
        logic [SEQ_LEN_W-1:0] len;
        int unsigned          v;
        len     = esc_len + 1'b1;
        esc_len = len;
        if (len == 2) begin
            esc_intro = c;
            if (c != CH_LBRACKET && c != CH_O) begin
                add_event(K_ESC, '0);
                if (c == CH_ESC) begin
                    open_escape();
                end else begin
                    esc_len = '0;
                    add_event(K_CP, CP_W'(c));
                end
                return;
            end
        end else if (esc_intro == CH_LBRACKET && len >= 3) begin
            if (c >= CH_FIN_LO && c <= CH_TILDE) begin
                finish_csi(len, c);
                esc_len = '0;
                return;
            end
            if (c >= CH_ZERO && c <= CH_NINE) begin
                v = int'(esc_num) * 10 + int'(c - CH_ZERO);
                esc_num = (v > NUM_SAT) ? NUM_SAT : v[NUM_W-1:0];
            end else begin
                esc_digits_ok = 1'b0;
            end
        end
        if (len >= SEQ_LIMIT)
            esc_len = '0;
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        t_key_event ev;
        byte_events.delete();
        if (esc_len != 0) begin
            escape_byte(c);
        end else if (utf_left != 0) begin
            if ((c & UTF_TRAIL_MASK) == UTF_TRAIL_VAL) begin
                utf_acc  = {utf_acc[CP_W-7:0], c[5:0]};
                utf_left = utf_left - 1'b1;
                if (utf_left == 0) begin
                    utf_nheld = '0;
                    if (utf_acc != 0)
                        add_event(K_CP, utf_acc);
                end else begin
                    utf_held[utf_nheld[0]] = c;
                    utf_nheld = utf_nheld + 1'b1;
                end
            end else begin
                // broken sequence: lead and held trails raw, then the byte afresh
                add_event(K_CP, CP_W'(utf_first));
                for (int i = 0; i < utf_nheld && i < 2; i++)
                    add_event(K_CP, CP_W'(utf_held[i]));
                utf_left  = '0;
                utf_nheld = '0;
                utf_acc   = '0;
                plain_key(c);
            end
        end else begin
            plain_key(c);
        end
        if (byte_events.size() > 0) begin
            ev = byte_events[byte_events.size() - 1];
            ev.last = 1'b1;
            byte_events[byte_events.size() - 1] = ev;
        end
        foreach (byte_events[i])
            awaited_events.push_back(byte_events[i]);
    endfunction

    always @(posedge i_clk) begin
        t_key_event want;
        if (!i_rst_n) begin
            esc_len       = '0;
            esc_intro     = '0;
            esc_num       = '0;
            esc_digits_ok = 1'b1;
            utf_acc       = '0;
            utf_left      = '0;
            utf_first     = '0;
            utf_nheld     = '0;
            utf_held[0]   = '0;
            utf_held[1]   = '0;
            awaited_events.delete();
        end else begin
            // events leave before the byte taken on the same edge adds its own
            if (i_m_tvalid && i_m_tready) begin
                o_events_seen++;
                if (awaited_events.size() == 0) begin
                    report_mismatch("key event with none expected", 32'(i_m_tdata), '0);
                end else begin
                    want = awaited_events.pop_front();
                    if (i_m_tuser !== want.kind)
                        report_mismatch("key_kind", 32'(i_m_tuser), 32'(want.kind));
                    if (i_m_tdata[20:0] !== want.cp)
                        report_mismatch("code_point", 32'(i_m_tdata[20:0]), 32'(want.cp));
                    if (i_m_tdata[23:21] !== '0)
                        report_mismatch("tdata padding", 32'(i_m_tdata[23:21]), '0);
                    if (i_m_tlast !== want.last)
                        report_mismatch("last_of_run", 32'(i_m_tlast), 32'(want.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_byte(i_s_tdata);
        end
        o_awaited = awaited_events.size();
    end

endmodule

### verif/terminal_key_byte_decoder_test.sv
// Testbench top for the terminal key byte decoder: clock, reset, byte
// stimulus, output back-pressure, watchdog and verdict.
// Depends on tkbd_pkg, terminal_key_byte_decoder and its checker.
`timescale 1ns / 1ps

module terminal_key_byte_decoder_test
    import tkbd_pkg::*;
();

    localparam int unsigned SEQ_LIMIT    = 64;
    localparam int unsigned N_ITEMS      = 410;
    localparam int unsigned RX_HOLD      = 300;
    localparam int unsigned IDLE_LIMIT   = 5000;
    localparam int unsigned DRAIN_CYCLES = 20;

    localparam int unsigned N_DIRECTED = 26;
    localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
        CH_NUL, CH_CTRL_C, CH_CTRL_Q, CH_BS, CH_DEL, CH_TAB, CH_LF, CH_CR,
        CH_ESC, CH_LBRACKET, CH_A,                   // up arrow
        CH_ESC, CH_LBRACKET, 8'h33, CH_TILDE,        // delete
        CH_ESC, CH_ESC, CH_NUL,                      // escape twice, then raw NUL
        8'hc3, 8'ha9,                                // two-byte codepoint
        8'hf0, 8'h80, 8'h80, CH_CTRL_C,              // broken four-byte lead, four events
        UTF_TRAIL_VAL, 8'hff                         // stray trail, invalid lead
    };
    localparam logic [7:0] CONTROL_BYTES [8] = '{
        CH_NUL, CH_CTRL_C, CH_CTRL_Q, CH_BS, CH_DEL, CH_TAB, CH_CR, CH_LF
    };
    localparam logic [7:0] CSI_FINALS [6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};

    typedef enum {
        PH_NOISE, PH_TEXT, PH_CONTROL, PH_CSI_KEY, PH_CSI_TILDE, PH_ESC_OTHER,
        PH_UTF_GOOD, PH_UTF_BROKEN, PH_STRAY, PH_CSI_LONG, PH_SS3
    } t_phrase;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int unsigned mismatches;
    int unsigned awaited;
    int unsigned events_seen;
    int unsigned bytes_sent;
    int unsigned n_swallowed;
    bit          rx_hold_due;
    bit          tx_calm;

    terminal_key_byte_decoder #(
        .SEQ_LIMIT (SEQ_LIMIT)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    terminal_key_byte_decoder_checker #(
        .SEQ_LIMIT (SEQ_LIMIT)
    ) chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_mismatches  (mismatches),
        .o_awaited     (awaited),
        .o_events_seen (events_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 100);
    endfunction

    // called and returns at a falling edge; tvalid is left high after the item
    task automatic send_byte(input logic [7:0] value, input bit swallowed = 1'b0);
        int unsigned idle;
        idle = tx_calm ? 0 : pick_gap();
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        bytes_sent++;
        if (swallowed)
            n_swallowed++;
    endtask

    // always moves on by at least one falling edge
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (awaited != 0);
    endtask

    task automatic send_phrase(input t_phrase kind);
        int unsigned n;
        int unsigned k;
        int unsigned num;
        logic [7:0]  b;
        string       digits;
        case (kind)
            PH_NOISE:   send_byte(8'($urandom_range(0, 255)));
            PH_TEXT:    send_byte(8'($urandom_range(8'h20, 8'h7e)));
            PH_CONTROL: send_byte(CONTROL_BYTES[$urandom_range(0, 7)]);
            PH_STRAY: begin
                if ($urandom_range(0, 1) == 0)
                    send_byte(UTF_TRAIL_VAL | 8'($urandom_range(0, 63)));
                else
                    send_byte(UTF_LEAD4_MASK | 8'($urandom_range(0, 7)));
            end
            PH_CSI_KEY: begin
                send_byte(CH_ESC);
                send_byte(CH_LBRACKET);
                if ($urandom_range(0, 9) < 7)
                    send_byte(CSI_FINALS[$urandom_range(0, 5)]);
                else
                    send_byte(8'($urandom_range(CH_FIN_LO, CH_TILDE)));
            end
            PH_CSI_TILDE: begin
                send_byte(CH_ESC);
                send_byte(CH_LBRACKET);
                case ($urandom_range(0, 3))
                    0:       num = 65536 + $urandom_range(0, 6);   // must saturate, not wrap
                    1:       num = $urandom_range(0, 99999);
                    default: num = $urandom_range(1, 6);
                endcase
                digits = $sformatf("%0d", num);
                if ($urandom_range(0, 7) == 0)
                    digits = {"0", digits};
                if ($urandom_range(0, 15) == 0)
                    digits = "";
                for (int i = 0; i < digits.len(); i++)
                    send_byte(digits[i]);
                // a random byte below 0x40 spoils the number unless it is a digit
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom_range(0, 8'h3f)));
                if ($urandom_range(0, 4) == 0)
                    send_byte(8'($urandom_range(CH_FIN_LO, CH_TILDE)));
                else
                    send_byte(CH_TILDE);
            end
            PH_ESC_OTHER: begin
                send_byte(CH_ESC);
                b = 8'($urandom_range(0, 255));
                if (b == CH_LBRACKET || b == CH_O || $urandom_range(0, 9) == 0)
                    b = CH_NUL;
                if ($urandom_range(0, 9) == 0)
                    b = CH_ESC;
                send_byte(b);
            end
            PH_UTF_GOOD, PH_UTF_BROKEN: begin
                if (kind == PH_UTF_GOOD && $urandom_range(0, 9) == 0) begin
                    // overlong NUL decodes to zero
                    send_byte(UTF_LEAD2_VAL);
                    send_byte(UTF_TRAIL_VAL);
                end else begin
                    n = $urandom_range(2, 4);
                    case (n)
                        2:       b = UTF_LEAD2_VAL | 8'($urandom_range(0, 31));
                        3:       b = UTF_LEAD3_VAL | 8'($urandom_range(0, 15));
                        default: b = UTF_LEAD4_VAL | 8'($urandom_range(0, 7));
                    endcase
                    send_byte(b);
                    k = (kind == PH_UTF_BROKEN) ? $urandom_range(0, n - 2) : n - 1;
                    repeat (k)
                        send_byte(UTF_TRAIL_VAL | 8'($urandom_range(0, 63)));
                    if (kind == PH_UTF_BROKEN) begin
                        b = 8'($urandom_range(0, 255));
                        if ((b & UTF_TRAIL_MASK) == UTF_TRAIL_VAL)
                            b = b | UTF_TRAIL_MASK;
                        send_byte(b);
                    end
                end
            end
            PH_CSI_LONG: begin
                send_byte(CH_ESC);
                send_byte(CH_LBRACKET);
                repeat (SEQ_LIMIT - 2)
                    send_byte(8'($urandom_range(8'h20, 8'h3f)), 1'b1);
            end
            PH_SS3: begin
                send_byte(CH_ESC);
                send_byte(CH_O);
                repeat (SEQ_LIMIT - 2)
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: ;
        endcase
    endtask

    // output side: random stalls, calm stretches and the long hold-off
    initial begin
        int unsigned stall;
        int unsigned calm_left;
        bit          calm;
        m_tready  = 1'b0;
        stall     = 0;
        calm_left = 0;
        calm      = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_due) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD - 1) @(negedge clk);
                rx_hold_due = 1'b0;
            end else if (stall != 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = calm ? 0 : pick_gap();
            end
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(20, 200);
            end else begin
                calm_left--;
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: nothing moved for %0d cycles, %0d events outstanding",
                         IDLE_LIMIT, awaited);
                $display("terminal_key_byte_decoder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int unsigned phrase;
        int unsigned calm_left;
        int unsigned r;
        bit          mid_done;
        t_phrase     kind;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rx_hold_due = 1'b0;
        tx_calm     = 1'b0;
        bytes_sent  = 0;
        n_swallowed = 0;
        calm_left   = 0;
        mid_done    = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);
        wait_drained();

        // output held off while bytes keep coming, so the input stalls
        rx_hold_due = 1'b1;
        phrase = 0;
        while (bytes_sent < N_ITEMS) begin
            if (calm_left == 0) begin
                tx_calm   = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(5, 25);
            end else begin
                calm_left--;
            end
            r = $urandom_range(0, 99);
            if      (r < 10) kind = PH_NOISE;
            else if (r < 25) kind = PH_TEXT;
            else if (r < 35) kind = PH_CONTROL;
            else if (r < 50) kind = PH_CSI_KEY;
            else if (r < 62) kind = PH_CSI_TILDE;
            else if (r < 70) kind = PH_ESC_OTHER;
            else if (r < 82) kind = PH_UTF_GOOD;
            else if (r < 92) kind = PH_UTF_BROKEN;
            else if (r < 98) kind = PH_STRAY;
            else if (r < 99) kind = PH_CSI_LONG;
            else             kind = PH_SS3;
            if (phrase == 3)
                kind = PH_SS3;
            if (phrase == 20)
                kind = PH_CSI_LONG;
            send_phrase(kind);
            phrase++;
            if (!mid_done && bytes_sent > N_ITEMS / 2) begin
                mid_done = 1'b1;
                wait_drained();
                rx_hold_due = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d input bytes (%0d inside over-long sequences), %0d key events",
                 bytes_sent, n_swallowed, events_seen);
        if (mismatches == 0)
            $display("terminal_key_byte_decoder: match");
        else
            $display("terminal_key_byte_decoder: mismatch");
        $finish;
    end

endmodule

### terminal_key_byte_decoder.f
rtl/tkbd_pkg.sv
rtl/tkbd_datapath.sv
rtl/tkbd_ctrl.sv
rtl/terminal_key_byte_decoder.sv
verif/terminal_key_byte_decoder_checker.sv
verif/terminal_key_byte_decoder_test.sv
